/* hdl/ohmi_pkg.sv */
// ohmi_pkg: shared types, codes and constants of the hex mesh indexer
// no dependencies; imported by ohmi_front, ohmi_back, the top level and the bench
`timescale 1ns / 1ps
`default_nettype none

package ohmi_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	localparam int         CFG_W      = 9;
	localparam logic [8:0] COLS_RESET = 9'd256;

	localparam int VTX_W  = 18;
	localparam int VOX_W  = 16;
	localparam int VCNT_W = 17;
	localparam int LAT_W  = 9;

	localparam int QUEUE_DEPTH = 4;

	// emit sequence: slots 0..7, then the pair above, then the pair to the left
	localparam logic [3:0] IDX_LAST_SLOT = 4'd7;
	localparam logic [3:0] IDX_UP        = 4'd8;
	localparam logic [3:0] IDX_LEFT      = 4'd9;

	typedef enum logic [1:0] {
		RK_CORNER = 2'd0,
		RK_ADJ    = 2'd1,
		RK_ERROR  = 2'd2
	} res_kind_t;

	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_EMIT
	} be_state_t;

	typedef struct packed {
		res_kind_t         kind;
		logic [2:0]        slot;
		logic [VTX_W-1:0]  vert;
		logic              is_new;
		logic [LAT_W-1:0]  lcol;
		logic [LAT_W-1:0]  lrow;
		logic              layer;
		logic [VOX_W-1:0]  vox;
		logic [VOX_W-1:0]  nb;
		logic              last;
	} result_t;

	// corner slots 1, 2, 5 and 6 sit on the right edge of the cell
	function automatic logic slot_right(input logic [2:0] s);
		return (s[1:0] == 2'd1) || (s[1:0] == 2'd2);
	endfunction

	// corner slots 2, 3, 6 and 7 sit on the bottom edge of the cell
	function automatic logic slot_bottom(input logic [2:0] s);
		return s[1];
	endfunction

endpackage

`default_nettype wire

/* hdl/ohmi_ram.sv */
// ohmi_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ohmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/ohmi_queue.sv */
// ohmi_queue: short register queue between the front and back parts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ohmi_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/ohmi_front.sv */
// ohmi_front: accepts bitmap items, tracks raster position and flags cells outside limits
// depends on ohmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module ohmi_front
	import ohmi_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	localparam int CW   = $clog2(MAX_COLUMNS + 1),
	localparam int RW   = $clog2(MAX_ROWS + 1),
	localparam int QW   = 4 + CW + RW,
	localparam int CMPW = (CW > CFG_W) ? CW : CFG_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] cfg_cols,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_cmd,
	input  wire logic             in_occ,
	input  wire logic             in_eor,
	input  wire logic             busy,
	input  wire logic             q_full,
	output logic                  q_push,
	output logic      [QW-1:0]    q_data
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          err;
	op_t           op;

	assign in_ready = !q_full && !busy;
	assign q_push   = in_valid && in_ready;
	assign op       = in_cmd ? OP_CLEAR : OP_CELL;

	assign err = (CMPW'(col_q) >= CMPW'(cfg_cols)) ||
	             (col_q >= CW'(MAX_COLUMNS)) ||
	             (row_q >= RW'(MAX_ROWS));

	assign q_data = {op, in_occ, in_eor, err, col_q, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (op == OP_CLEAR) begin
				col_q <= '0;
				row_q <= '0;
			end else if (in_eor) begin
				col_q <= '0;
				if (row_q < RW'(MAX_ROWS)) begin
					row_q <= row_q + RW'(1);
				end
			end else if (col_q < CW'(MAX_COLUMNS)) begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/ohmi_back.sv */
// ohmi_back: numbers voxels and corners, looks up shared corners and neighbors, emits results
// depends on ohmi_pkg and ohmi_ram
`timescale 1ns / 1ps
`default_nettype none

module ohmi_back
	import ohmi_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	localparam int CW     = $clog2(MAX_COLUMNS + 1),
	localparam int RW     = $clog2(MAX_ROWS + 1),
	localparam int QW     = 4 + CW + RW,
	localparam int CDEPTH = MAX_COLUMNS / 2 + 1,
	localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1,
	localparam int PAW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int CEW    = 1 + RW + VTX_W,
	localparam int PEW    = 1 + RW + VOX_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire logic [QW-1:0] q_data,
	output logic               q_pop,
	output logic               busy,
	output logic               out_valid,
	input  wire logic          out_ready,
	output result_t            out_res
);

	be_state_t st_q, st_d;

	logic                cur_occ_q, cur_eor_q, cur_err_q;
	logic [CW-1:0]       cur_col_q;
	logic [RW-1:0]       cur_row_q;
	logic [3:0]          idx_q;
	logic [VCNT_W-1:0]   vox_cnt_q;
	logic [VTX_W-1:0]    vtx_cnt_q;
	logic                left_vld_q;
	logic [VOX_W-1:0]    left_vox_q;
	logic [PAW-1:0]      clr_cnt_q;
	logic                ov_q;
	result_t             res_q;

	// queue head
	op_t                 h_op;
	logic [CW-1:0]       h_col;
	logic [CW:0]         h_lc_even, h_lc_odd;

	// corner tables, one ram per layer, lattice row parity and lattice column parity
	logic [CEW-1:0]      c_rd [8];
	logic [7:0]          c_we;
	logic [CAW-1:0]      c_wa, c_ra_even, c_ra_odd;
	logic [CEW-1:0]      c_wd;
	logic                rd_en;

	// voxels of the row above
	logic                p_we;
	logic [PEW-1:0]      p_wd, p_rd;
	logic [PAW-1:0]      p_wa;
	logic                up_vld;

	// current slot geometry
	logic [2:0]          s;
	logic                rgt, bot;
	logic [RW-1:0]       lrow;
	logic [CW-1:0]       lcol;
	logic [2:0]          j;
	logic [CEW-1:0]      ent;
	logic                hit;
	logic [VTX_W-1:0]    vert;
	logic                is_slot;

	logic                emit, load, finish, last;
	logic [3:0]          idx_nxt;
	result_t             res_d;

	assign h_op      = op_t'(q_data[QW-1]);
	assign h_col     = q_data[RW+CW-1:RW];
	assign h_lc_even = {1'b0, h_col} + (CW+1)'(h_col[0]);
	assign h_lc_odd  = {1'b0, h_col} + (CW+1)'(!h_col[0]);
	assign c_ra_even = CAW'(h_lc_even >> 1);
	assign c_ra_odd  = CAW'(h_lc_odd >> 1);

	assign busy = (st_q == ST_CLEAR);

	for (genvar g = 0; g < 8; g++) begin : g_corner
		ohmi_ram #(
			.WIDTH(CEW),
			.DEPTH(CDEPTH)
		) u_corner_ram (
			.clk  (clk),
			.we   (c_we[g]),
			.waddr(c_wa),
			.wdata(c_wd),
			.re   (rd_en),
			.raddr((g % 2 == 0) ? c_ra_even : c_ra_odd),
			.rdata(c_rd[g])
		);
	end

	ohmi_ram #(
		.WIDTH(PEW),
		.DEPTH(MAX_COLUMNS)
	) u_prev_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_wa),
		.wdata(p_wd),
		.re   (rd_en),
		.raddr(PAW'(h_col)),
		.rdata(p_rd)
	);

	// an entry of the row above counts only if it was written on the previous row
	assign up_vld = p_rd[PEW-1] && ((p_rd[PEW-2:VOX_W] + RW'(1)) == cur_row_q);

	always_comb begin
		s       = idx_q[2:0];
		rgt     = slot_right(s);
		bot     = slot_bottom(s);
		lrow    = cur_row_q + RW'(bot);
		lcol    = cur_col_q + CW'(rgt);
		j       = {s[2], lrow[0], lcol[0]};
		ent     = c_rd[j];
		hit     = ent[CEW-1] && (ent[CEW-2:VTX_W] == lrow);
		vert    = hit ? ent[VTX_W-1:0] : vtx_cnt_q;
		is_slot = (idx_q <= IDX_LAST_SLOT);
	end

	always_comb begin
		priority if (is_slot && idx_q != IDX_LAST_SLOT) begin
			idx_nxt = idx_q + 4'd1;
			last    = 1'b0;
		end else if (is_slot) begin
			idx_nxt = up_vld ? IDX_UP : IDX_LEFT;
			last    = !up_vld && !left_vld_q;
		end else if (idx_q == IDX_UP) begin
			idx_nxt = IDX_LEFT;
			last    = !left_vld_q;
		end else begin
			idx_nxt = IDX_LEFT;
			last    = 1'b1;
		end
	end

	assign load = emit && (!ov_q || out_ready);

	always_comb begin
		st_d   = st_q;
		q_pop  = 1'b0;
		rd_en  = 1'b0;
		emit   = 1'b0;
		finish = 1'b0;
		res_d  = '0;
		c_we   = '0;
		c_wa   = CAW'(lcol >> 1);
		c_wd   = {1'b1, lrow, vtx_cnt_q};
		p_we   = 1'b0;
		p_wa   = PAW'(cur_col_q);
		p_wd   = '0;
		unique case (st_q)
			ST_CLEAR: begin
				c_wa = CAW'(clr_cnt_q);
				c_wd = '0;
				c_we = (int'(clr_cnt_q) < CDEPTH) ? 8'hff : 8'h00;
				p_we = 1'b1;
				p_wa = clr_cnt_q;
				if (clr_cnt_q == PAW'(MAX_COLUMNS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (h_op == OP_CLEAR) begin
						st_d = ST_CLEAR;
					end else begin
						rd_en = 1'b1;
						st_d  = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (cur_err_q) begin
					emit       = 1'b1;
					res_d.kind = RK_ERROR;
					res_d.last = 1'b1;
					if (load) begin
						// keep the row-above entry alive across an error cell
						p_we   = (cur_col_q < CW'(MAX_COLUMNS));
						p_wd   = {up_vld, cur_row_q, p_rd[VOX_W-1:0]};
						finish = 1'b1;
						st_d   = ST_IDLE;
					end
				end else if (!cur_occ_q) begin
					p_we   = 1'b1;
					finish = 1'b1;
					st_d   = ST_IDLE;
				end else begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit      = 1'b1;
				res_d.vox = vox_cnt_q[VOX_W-1:0];
				res_d.last = last;
				if (is_slot) begin
					res_d.kind   = RK_CORNER;
					res_d.slot   = s;
					res_d.vert   = vert;
					res_d.is_new = !hit;
					res_d.lcol   = LAT_W'(lcol);
					res_d.lrow   = LAT_W'(lrow);
					res_d.layer  = s[2];
				end else begin
					res_d.kind = RK_ADJ;
					res_d.nb   = (idx_q == IDX_UP) ? p_rd[VOX_W-1:0] : left_vox_q;
				end
				if (load) begin
					if (is_slot && !hit) begin
						c_we[j] = 1'b1;
					end
					if (last) begin
						p_we   = 1'b1;
						p_wd   = {1'b1, cur_row_q, vox_cnt_q[VOX_W-1:0]};
						finish = 1'b1;
						st_d   = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_occ_q <= q_data[QW-2];
			cur_eor_q <= q_data[QW-3];
			cur_err_q <= q_data[QW-4];
			cur_col_q <= h_col;
			cur_row_q <= q_data[RW-1:0];
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			vox_cnt_q  <= '0;
			vtx_cnt_q  <= '0;
			left_vld_q <= 1'b0;
			left_vox_q <= '0;
			clr_cnt_q  <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (st_q == ST_CLEAR) begin
				clr_cnt_q  <= clr_cnt_q + PAW'(1);
				vox_cnt_q  <= '0;
				vtx_cnt_q  <= '0;
				left_vld_q <= 1'b0;
			end else begin
				clr_cnt_q <= '0;
			end
			if (st_q == ST_DECIDE) begin
				idx_q <= '0;
			end else if (st_q == ST_EMIT && load && !last) begin
				idx_q <= idx_nxt;
			end
			if (st_q == ST_EMIT && load && is_slot && !hit) begin
				vtx_cnt_q <= vtx_cnt_q + VTX_W'(1);
			end
			if (finish) begin
				if (cur_occ_q && !cur_err_q) begin
					vox_cnt_q <= vox_cnt_q + VCNT_W'(1);
				end
				// end of row wins over the voxel just placed
				if (cur_eor_q) begin
					left_vld_q <= 1'b0;
				end else if (!cur_err_q) begin
					left_vld_q <= cur_occ_q;
					left_vox_q <= vox_cnt_q[VOX_W-1:0];
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign out_res   = res_q;

	ap_vtx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && load && is_slot && !hit) |=>
		(vtx_cnt_q == $past(vtx_cnt_q) + VTX_W'(1)))
		else $error("vertex counter did not advance on a new corner");

	ap_one_corner_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_CLEAR) |-> $onehot0(c_we))
		else $error("more than one corner table written in a cycle");

	ap_last_ends_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_d.last) |=> (st_q == ST_IDLE))
		else $error("cell still in progress after its last result");

	ap_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q == ST_CLEAR || st_q == ST_DECIDE))
		else $error("popped item not taken up");

endmodule

`default_nettype wire

/* hdl/occupancy_grid_to_hex_mesh_indexer_core.sv */
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata[0] occupied, tuser command, tlast end of row
// m_axis   | out | m_axis_tvalid/tready      | tdata corner/adjacency fields, tuser kind, tlast last
// apb      | in  | psel, penable, pready     | register 0 columns_in_use at byte address 0
//
// in the back part an empty cell gives no result and an error cell one; an occupied cell
// reads the tables, then loads its results one after another into the output register
// after reset, and after a start-grid command reaches the back part, a clearing pass
// sweeps every table entry; s_axis_tready is low during it
// a 4-entry queue lets the input side run ahead while results stall on m_axis
// top level of the hex mesh indexer; depends on ohmi_pkg, ohmi_front, ohmi_queue, ohmi_back
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_to_hex_mesh_indexer_core
	import ohmi_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] cell_occupied, [7:1] zero
	input  wire logic [0:0]  s_axis_tuser,   // [0] command
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] corner_slot, [20:3] vertex_number, [21] vertex_is_new, [30:22] lattice_column,
	// [39:31] lattice_row, [40] layer, [56:41] voxel_number, [72:57] neighbor_voxel
	output logic [79:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int QW = 4 + CW + RW;

	logic [CFG_W-1:0] cols_q;
	logic             q_push, q_full, q_pop, q_valid, busy;
	logic [QW-1:0]    q_din, q_dout;
	result_t          res;

	assign pready = 1'b1;
	assign prdata = 32'(cols_q);

	// single register; every address maps onto it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == paddr)) begin
			cols_q <= pwdata[CFG_W-1:0];
		end
	end

	ohmi_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_cols(cols_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd  (s_axis_tuser[0]),
		.in_occ  (s_axis_tdata[0]),
		.in_eor  (s_axis_tlast),
		.busy    (busy),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_din)
	);

	ohmi_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_dout)
	);

	ohmi_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_dout),
		.q_pop    (q_pop),
		.busy     (busy),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = {7'd0, res.nb, res.vox, res.layer, res.lrow, res.lcol,
	                       res.is_new, res.vert, res.slot};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for the hex mesh indexer core, directed cells and rows then random grids
// checks every m_axis transfer against an in-bench mesh indexing predictor; needs ohmi_pkg
`timescale 1ns / 1ps

module tb;
	import ohmi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [0] cell_occupied, [7:1] zero
	logic [0:0]  s_axis_tuser;   // [0] command
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // slot, vertex, new, lcol, lrow, layer, voxel, neighbor
	logic [1:0]  m_axis_tuser;   // [1:0] result_kind
	logic        m_axis_tlast;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	occupancy_grid_to_hex_mesh_indexer_core dut (.*);

	// mesh indexer model state
	logic [8:0]  cols_reg;
	logic [16:0] vox_cnt;
	logic [17:0] vtx_cnt;
	int          col_pos, row_pos;
	logic [16:0] above_vox[256];
	logic [16:0] left_vox;
	logic [18:0] top_edge[2][257];
	logic [18:0] bot_edge[2][257];

	result_t mesh_q[$];
	int      mismatches;
	int      fails;
	bit      calm;

	typedef struct {
		bit cmd;
		bit occ;
		bit eor;
		bit want_err;
	} cell_row_t;

	function automatic void clear_grid();
		vox_cnt = '0;
		vtx_cnt = '0;
		col_pos = 0;
		row_pos = 0;
		left_vox = '0;
		foreach (above_vox[i]) above_vox[i] = '0;
		for (int l = 0; l < 2; l++)
			for (int i = 0; i < 257; i++) begin
				top_edge[l][i] = '0;
				bot_edge[l][i] = '0;
			end
	endfunction

	function automatic void index_cell(input bit cmd, input bit occ, input bit eor);
		int      width;
		int      n;
		int      lc;
		int      lay;
		int      k;
		bit      bot;
		logic [15:0] vn;
		logic [17:0] v;
		bit      isnew;
		result_t r[10];
		width = (cols_reg < 256) ? cols_reg : 256;
		n = 0;
		if (cmd == OP_CLEAR) begin
			clear_grid();
			return;
		end
		if (col_pos >= width || row_pos >= 256) begin
			r[0] = '{kind: RK_ERROR, default: '0};
			n = 1;
		end else if (occ) begin
			vn = vox_cnt[15:0];
			for (int s = 0; s < 8; s++) begin
				k = s & 3;
				lay = s >> 2;
				lc = col_pos + ((k == 1 || k == 2) ? 1 : 0);
				bot = (k >= 2);
				if (bot) begin
					if (bot_edge[lay][lc][18]) begin
						v = bot_edge[lay][lc][17:0];
						isnew = 0;
					end else begin
						v = vtx_cnt;
						bot_edge[lay][lc] = {1'b1, v};
						vtx_cnt = vtx_cnt + 1'b1;
						isnew = 1;
					end
				end else begin
					if (top_edge[lay][lc][18]) begin
						v = top_edge[lay][lc][17:0];
						isnew = 0;
					end else begin
						v = vtx_cnt;
						top_edge[lay][lc] = {1'b1, v};
						vtx_cnt = vtx_cnt + 1'b1;
						isnew = 1;
					end
				end
				r[n] = '{kind: RK_CORNER, slot: 3'(s), vert: v, is_new: isnew,
					lcol: 9'(lc), lrow: 9'(row_pos + (bot ? 1 : 0)), layer: 1'(lay),
					vox: vn, default: '0};
				n++;
			end
			if (above_vox[col_pos][16]) begin
				r[n] = '{kind: RK_ADJ, vox: vn, nb: above_vox[col_pos][15:0], default: '0};
				n++;
			end
			if (left_vox[16]) begin
				r[n] = '{kind: RK_ADJ, vox: vn, nb: left_vox[15:0], default: '0};
				n++;
			end
			above_vox[col_pos] = {1'b1, vn};
			left_vox = {1'b1, vn};
			vox_cnt = vox_cnt + 1'b1;
		end else begin
			above_vox[col_pos] = '0;
			left_vox = '0;
		end
		if (eor) begin
			for (int i = col_pos + 1; i < 256; i++) above_vox[i] = '0;
			for (int l = 0; l < 2; l++)
				for (int i = 0; i < 257; i++) begin
					top_edge[l][i] = bot_edge[l][i];
					bot_edge[l][i] = '0;
				end
			col_pos = 0;
			if (row_pos < 256) row_pos++;
			left_vox = '0;
		end else if (col_pos < 256) begin
			col_pos++;
		end
		if (n > 0) r[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) mesh_q = {mesh_q, r[i]};
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls per transfer
	initial begin
		int n;
		m_axis_tready <= 1'b0;
		forever begin
			n = calm ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		bit      bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (mesh_q.size() == 0) begin
				fails++;
				if (mismatches < 10)
					$display("unexpected transfer kind=%0d tdata=%h", m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = mesh_q.pop_front();
				bad = (m_axis_tuser != want.kind) || (m_axis_tdata[2:0] != want.slot)
					|| (m_axis_tdata[20:3] != want.vert) || (m_axis_tdata[21] != want.is_new)
					|| (m_axis_tdata[30:22] != want.lcol) || (m_axis_tdata[39:31] != want.lrow)
					|| (m_axis_tdata[40] != want.layer) || (m_axis_tdata[56:41] != want.vox)
					|| (m_axis_tdata[72:57] != want.nb) || (m_axis_tlast != want.last);
				if (bad) begin
					fails++;
					if (mismatches < 10)
						$display("mismatch exp k=%0d s=%0d v=%0d n=%0d c=%0d r=%0d l=%0d x=%0d nb=%0d t=%0d | act k=%0d s=%0d v=%0d n=%0d c=%0d r=%0d l=%0d x=%0d nb=%0d t=%0d",
							want.kind, want.slot, want.vert, want.is_new, want.lcol, want.lrow,
							want.layer, want.vox, want.nb, want.last,
							m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[20:3], m_axis_tdata[21],
							m_axis_tdata[30:22], m_axis_tdata[39:31], m_axis_tdata[40],
							m_axis_tdata[56:41], m_axis_tdata[72:57], m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	task automatic send_cell(input bit cmd, input bit occ, input bit eor, input bit want_err);
		int n;
		n = calm ? 0 : $urandom_range(0, 16);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {7'd0, occ};
		s_axis_tlast  <= eor;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		index_cell(cmd, occ, eor);
		if (want_err) begin
			mesh_q[mesh_q.size() - 1] = '{kind: RK_ERROR, last: 1'b1, default: '0};
		end
	endtask

	// lets the block finish all pending work before a register write or the end
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (mesh_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cols(input logic [8:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= '0;
		pwdata  <= {23'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cols_reg = val;
	endtask

	// random rows of a random grid, some start-grid commands and runaway rows
	task automatic random_grid(input int items);
		int len;
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0) calm = ~calm;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 49) == 0)
					send_cell(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1), 0);
				else
					send_cell(OP_CELL, $urandom_range(0, 9) < 6, (i == len - 1), 0);
				sent++;
			end
		end
	endtask

	cell_row_t dir_tab[17] = '{
		'{0, 1, 0, 0}, '{0, 1, 0, 0}, '{0, 1, 1, 1},
		'{0, 1, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 1, 1},
		'{0, 0, 1, 0}, '{0, 1, 1, 0}, '{0, 1, 0, 0},
		'{1, 1, 1, 0}, '{0, 1, 0, 0}, '{0, 1, 1, 0},
		'{0, 1, 0, 0}, '{0, 1, 1, 0}, '{0, 0, 0, 0},
		'{0, 1, 0, 0}, '{0, 1, 1, 1}
	};

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		mismatches    = 0;
		fails         = 0;
		calm          = 0;
		cols_reg      = COLS_RESET;
		clear_grid();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width first: a single occupied cell, all corners new
		send_cell(OP_CELL, 1, 1, 0);
		drain();
		write_cols(9'd2);
		foreach (dir_tab[i])
			send_cell(dir_tab[i].cmd, dir_tab[i].occ, dir_tab[i].eor, dir_tab[i].want_err);
		drain();

		// one-cell rows that run past the last row
		write_cols(9'd1);
		send_cell(OP_CLEAR, 0, 0, 0);
		calm = 1;
		for (int i = 0; i < 258; i++)
			send_cell(OP_CELL, (i < 3) || (i > 253), 1, 0);
		calm = 0;
		send_cell(OP_CLEAR, 0, 0, 0);
		drain();

		write_cols(9'd5);
		random_grid(25);
		drain();
		write_cols(9'd511);
		random_grid(20);
		drain();
		write_cols(9'd0);
		random_grid(8);
		drain();
		write_cols(9'd17);
		send_cell(OP_CLEAR, 0, 0, 0);
		random_grid(20);
		drain();

		if (fails == 0 && mesh_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
